// ===== hw/rtl/request_packet_validator_assert.svh =====
// Assertion macros shared by the validator modules.
`ifndef REQUEST_PACKET_VALIDATOR_ASSERT_SVH
`define REQUEST_PACKET_VALIDATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RPV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the following cycle.
`define RPV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rpv_pkg.sv =====
`default_nettype none
package rpv_pkg;

  localparam int PacketBytes = 36;
  localparam logic [5:0] CountSat = 6'(PacketBytes + 1);
  localparam logic [5:0] XorStart = 6'd12;
  localparam logic [31:0] MaxPointsReset = 32'd1024;
  localparam logic [31:0] TimeWindowReset = 32'd180;
  localparam logic [31:0] AbsMask = 32'h7FFF_FFFF;
  localparam logic [31:0] ExpMask = 32'h7F80_0000;
  localparam logic [31:0] LatBound = 32'h42B4_0000;
  localparam logic [31:0] LonBound = 32'h4334_0000;
  localparam int QueueDepth = 2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StBadRequest = 2'd1;
  localparam logic [1:0] StBadPoints = 2'd2;
  localparam logic [1:0] StTime = 2'd3;

  localparam logic CfgMaxPoints = 1'b0;
  localparam logic CfgTimeWindow = 1'b1;

  typedef struct packed {
    logic [7:0] byte_value;
    logic last_byte;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] server_time;
    logic [31:0] point_count;
    logic [31:0] request_time;
    logic [31:0] object_id;
    logic [31:0] altitude_value;
    logic [31:0] latitude_bits;
    logic [31:0] longitude_bits;
  } out_word_t;

  // A gathered packet handed from the front part to the checker.
  typedef struct packed {
    logic size_ok;
    logic [31:0] now;
    logic [31:0] xor_sum;
    logic [8:0][31:0] words;
  } pkt_t;

  // True when the float is NaN or within +-bound.
  function automatic logic within_bound(logic [31:0] bits, logic [31:0] bound);
    logic [31:0] mag;
    mag = bits & AbsMask;
    return (mag > ExpMask) || (mag <= bound);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rpv_front.sv =====
`default_nettype none
// Gathers bytes into words and builds the XOR of words 3 to 8.
module rpv_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire rpv_pkg::in_word_t in_data,
  output logic pkt_valid,
  input  wire logic pkt_ready,
  output rpv_pkg::pkt_t pkt_data
);
  logic [8:0][31:0] store_r;
  logic [31:0] xor_r, xor_nxt;
  logic [5:0] count_r, count_nxt;
  logic accept, is_last;
  logic [31:0] lane;

  // A byte is taken unless a final byte would find the queue full.
  assign in_ready = pkt_ready;
  assign accept = in_valid && in_ready;
  assign is_last = in_data.last_byte;

  always_comb begin
    lane = 32'(in_data.byte_value) << {count_r[1:0], 3'b000};
    xor_nxt = xor_r;
    count_nxt = count_r;
    if (count_r < 6'(rpv_pkg::PacketBytes) && count_r >= rpv_pkg::XorStart) begin
      xor_nxt = xor_r ^ lane;
    end
    if (count_r < rpv_pkg::CountSat) begin
      count_nxt = count_r + 6'd1;
    end
  end

  // Each byte lands in its word at the lane given by the low count bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r <= '0;
      count_r <= '0;
      store_r <= '0;
    end else if (accept) begin
      if (count_r < 6'(rpv_pkg::PacketBytes)) begin
        store_r[count_r[5:2]][{count_r[1:0], 3'b000} +: 8] <= in_data.byte_value;
      end
      xor_r <= is_last ? '0 : xor_nxt;
      count_r <= is_last ? '0 : count_nxt;
    end
  end

  // The packet view includes the final byte being accepted now.
  always_comb begin
    logic [8:0][31:0] view;
    view = store_r;
    if (count_r < 6'(rpv_pkg::PacketBytes)) begin
      view[count_r[5:2]][{count_r[1:0], 3'b000} +: 8] = in_data.byte_value;
    end
    pkt_data.words = view;
    pkt_data.xor_sum = xor_nxt;
    pkt_data.now = in_data.now_seconds;
    pkt_data.size_ok = (count_nxt == 6'(rpv_pkg::PacketBytes));
  end
  assign pkt_valid = in_valid && is_last;

  `include "request_packet_validator_assert.svh"
  `RPV_ASSERT_NEXT(a_count_clear, clk, rst_n, accept && is_last, count_r == 6'd0)
  `RPV_ASSERT_IMPLY(a_count_sat, clk, rst_n, 1'b1, count_r <= rpv_pkg::CountSat)
  `RPV_ASSERT_NEXT(a_xor_clear, clk, rst_n, accept && is_last, xor_r == 32'd0)
endmodule
`default_nettype wire

// ===== hw/rtl/rpv_queue.sv =====
`default_nettype none
// Short queue between the front part and the checker.
module rpv_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic wr_ready,
  input  wire rpv_pkg::pkt_t wr_data,
  output logic rd_valid,
  input  wire logic rd_ready,
  output rpv_pkg::pkt_t rd_data
);
  rpv_pkg::pkt_t mem_r [rpv_pkg::QueueDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;

  assign wr_ready = cnt_r != 2'(rpv_pkg::QueueDepth);
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `include "request_packet_validator_assert.svh"
  `RPV_ASSERT_IMPLY(a_no_overflow, clk, rst_n, 1'b1, cnt_r <= 2'(rpv_pkg::QueueDepth))
  `RPV_ASSERT_NEXT(a_pop_moves, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - 2'd1)
  `RPV_ASSERT_NEXT(a_push_moves, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 2'd1)
endmodule
`default_nettype wire

// ===== hw/rtl/rpv_check.sv =====
`default_nettype none
// Runs the ordered checks and holds the result in an output register.
module rpv_check (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic [31:0] point_limit,
  input  wire logic [31:0] time_window,
  input  wire logic pkt_valid,
  output logic pkt_ready,
  input  wire rpv_pkg::pkt_t pkt_data,
  output logic out_valid,
  input  wire logic out_ready,
  output rpv_pkg::out_word_t out_data
);
  logic valid_r;
  rpv_pkg::out_word_t res_r, res_nxt;
  logic [31:0] diff;

  assign pkt_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data = res_r;

  always_comb begin
    logic [8:0][31:0] w;
    w = pkt_data.words;
    diff = (w[3] >= pkt_data.now) ? w[3] - pkt_data.now : pkt_data.now - w[3];
    res_nxt = '0;
    if (!pkt_data.size_ok) begin
      res_nxt.status = rpv_pkg::StBadRequest;
    end else begin
      res_nxt.server_time = w[0];
      res_nxt.point_count = w[1];
      res_nxt.request_time = w[3];
      res_nxt.object_id = w[4];
      res_nxt.altitude_value = w[6];
      res_nxt.latitude_bits = w[7];
      res_nxt.longitude_bits = w[8];
      if (w[2] != pkt_data.xor_sum || w[5] != 32'd0) begin
        res_nxt.status = rpv_pkg::StBadRequest;
      end else if (w[1] == 32'd0 || w[1] > point_limit) begin
        res_nxt.status = rpv_pkg::StBadPoints;
      end else if (!rpv_pkg::within_bound(w[7], rpv_pkg::LatBound) ||
                   !rpv_pkg::within_bound(w[8], rpv_pkg::LonBound)) begin
        res_nxt.status = rpv_pkg::StBadRequest;
      end else if (diff > time_window) begin
        res_nxt.status = rpv_pkg::StTime;
      end else begin
        res_nxt.status = rpv_pkg::StOk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pkt_ready) begin
      valid_r <= pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_ready && pkt_valid) begin
      res_r <= res_nxt;
    end
  end

  `include "request_packet_validator_assert.svh"
  `RPV_ASSERT_NEXT(a_hold, clk, rst_n, valid_r && !out_ready, valid_r && $stable(res_r))
  `RPV_ASSERT_IMPLY(a_zero_points, clk, rst_n, valid_r && res_r.point_count == 32'd0,
    res_r.status == rpv_pkg::StBadRequest || res_r.status == rpv_pkg::StBadPoints)
  `RPV_ASSERT_NEXT(a_take, clk, rst_n, pkt_valid && pkt_ready, valid_r)
endmodule
`default_nettype wire

// ===== hw/rtl/request_packet_validator.sv =====
// Channel | Handshake            | Payload
// in      | in_valid/in_ready    | in_data (byte_value, last_byte, now_seconds)
// out     | out_valid/out_ready  | out_data (status and seven packet words)
// cfg     | cfg_we               | cfg_index, cfg_wdata
// One byte is taken each cycle unless in_ready is low. Accepting a final byte puts
// the packet into the two-entry queue; the checker then takes it from the queue
// and registers the result, which is held until out_ready takes it.
// A final byte waits only while the queue is full; other bytes always pass.
// Reset is synchronous, active low, and restores the register defaults.
`default_nettype none
module request_packet_validator (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire rpv_pkg::in_word_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output rpv_pkg::out_word_t out_data,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  logic [31:0] point_limit_r, time_window_r;
  logic f_valid, f_ready, q_valid, q_ready, q_wr_ready;
  rpv_pkg::pkt_t f_data, q_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_limit_r <= rpv_pkg::MaxPointsReset;
      time_window_r <= rpv_pkg::TimeWindowReset;
    end else if (cfg_we) begin
      case (cfg_index[0])
        rpv_pkg::CfgMaxPoints: point_limit_r <= cfg_wdata;
        rpv_pkg::CfgTimeWindow: time_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Non-final bytes never need queue room.
  assign f_ready = q_wr_ready || !in_data.last_byte;

  rpv_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .pkt_valid(f_valid), .pkt_ready(f_ready), .pkt_data(f_data)
  );
  rpv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(f_valid && in_ready), .wr_ready(q_wr_ready),
    .wr_data(f_data), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );
  rpv_check u_check (
    .clk(clk), .rst_n(rst_n), .point_limit(point_limit_r), .time_window(time_window_r),
    .pkt_valid(q_valid), .pkt_ready(q_ready), .pkt_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire
